// ===== hw/rtl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// shared types, codes and helpers of the first-free bitmap allocator
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int WORD_BITS    = 32;
    localparam int MAP_BITS_DEF = 8192;
    localparam int ENTRY_W      = 14;
    localparam int STATUS_W     = 2;
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;

    localparam logic [ENTRY_W-1:0] LIMIT_RESET = 14'd8192;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic
    {
        REG_ENTRY_LIMIT = 1'b0
    } reg_idx_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE_RD,
        ST_FREE_MOD,
        ST_RESP
    } state_t;

    // position of the lowest set bit of a word
    function automatic logic [4:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [4:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ===== hw/rtl/bfa_req_if.sv =====
// ----------------------------------------------------------------------------
// bfa_req_if
// request channel: allocate or free an entry
// ----------------------------------------------------------------------------
interface bfa_req_if;

    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [bfa_pkg::ENTRY_W-1:0]  entry_index;

    modport source
    (
        output valid,
        input  ready,
        output operation,
        output entry_index
    );

    modport sink
    (
        input  valid,
        output ready,
        input  operation,
        input  entry_index
    );

endinterface

// ===== hw/rtl/bfa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bfa_rsp_if
// response channel: entry number, status and free count of one request
// ----------------------------------------------------------------------------
interface bfa_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [bfa_pkg::ENTRY_W-1:0]   entry_number;
    logic [bfa_pkg::STATUS_W-1:0]  status;
    logic [bfa_pkg::ENTRY_W-1:0]   free_count;

    modport source
    (
        output valid,
        input  ready,
        output entry_number,
        output status,
        output free_count
    );

    modport sink
    (
        input  valid,
        output ready,
        input  entry_number,
        input  status,
        input  free_count
    );

endinterface

// ===== hw/rtl/bitmap_first_free_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// first-free entry allocator over a word-wide usage bitmap in block memory
// ----------------------------------------------------------------------------
// allocate: scan from word zero (up to 256 words) to a free bit or the last word
// free: read, then modify-write; an out-of-range entry skips to the response
// one request at a time; the single map read port scans one 32-bit word a cycle
// reset: clearing pass over MAP_BITS/32 words (256 by default) before requests
// are taken; entry limit resets to 8192, used count to zero
module bitmap_first_free_allocator #(
    parameter int MAP_BITS = bfa_pkg::MAP_BITS_DEF
)(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bfa_pkg::ADDR_W-1:0]  paddr,
    input  logic [bfa_pkg::DATA_W-1:0]  pwdata,
    output logic [bfa_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,

    bfa_req_if.sink                     req,
    bfa_rsp_if.source                   rsp
);

    localparam int WB        = bfa_pkg::WORD_BITS;
    localparam int EW        = bfa_pkg::ENTRY_W;
    localparam int WORDS     = (MAP_BITS + WB - 1) / WB;
    localparam int WA        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW        = ((WA + 5 > EW) ? WA + 5 : EW) + 1;
    localparam int LIM_CAP   = (MAP_BITS > (2 ** EW) - 1) ? (2 ** EW) - 1 : MAP_BITS;

    localparam logic [WA-1:0] LAST_WORD = WA'(WORDS - 1);

    logic [WB-1:0] map_mem [WORDS];

    bfa_pkg::state_t      state_reg, state_next;
    logic [EW-1:0]        limit_reg;
    logic [EW-1:0]        used_reg;
    logic [EW-1:0]        idx_reg;
    logic [WA-1:0]        clr_addr_reg;
    logic [WA-1:0]        scan_addr_reg;
    logic [WA-1:0]        chk_addr_reg;
    logic                 chk_valid_reg;
    logic [WB-1:0]        rdata_reg;
    logic [EW-1:0]        res_number_reg;
    logic [1:0]           res_status_reg;
    logic                 out_valid_reg;
    logic [EW-1:0]        out_number_reg;
    logic [1:0]           out_status_reg;
    logic [EW-1:0]        out_free_reg;

    logic [EW-1:0]        lim;
    logic [EW-1:0]        free_left;
    logic                 cfg_write;
    logic                 accept;
    logic                 idx_bad;
    logic [EW-1:0]        free_bit;

    logic [BW-1:0]        base_w;
    logic [BW-1:0]        lim_w;
    logic [BW-1:0]        rem_w;
    logic [WB-1:0]        mask;
    logic [WB-1:0]        free_bits;
    logic                 found;
    logic                 last_word;
    logic [4:0]           pos;
    logic                 free_hit;

    logic                 rd_en;
    logic [WA-1:0]        rd_addr;
    logic                 wr_en;
    logic [WA-1:0]        wr_addr;
    logic [WB-1:0]        wr_data;
    logic                 out_load;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[bfa_pkg::ADDR_W-1:2] == bfa_pkg::REG_ENTRY_LIMIT)
                       ? bfa_pkg::DATA_W'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= bfa_pkg::LIMIT_RESET;
        end
        else if (cfg_write && paddr[bfa_pkg::ADDR_W-1:2] == bfa_pkg::REG_ENTRY_LIMIT)
        begin
            limit_reg <= pwdata[EW-1:0];
        end
    end

    // effective limit and free count
    always_comb
    begin
        lim       = (limit_reg > EW'(LIM_CAP)) ? EW'(LIM_CAP) : limit_reg;
        free_left = (lim > used_reg) ? lim - used_reg : '0;
        accept    = req.valid && req.ready;
        idx_bad   = (req.entry_index == '0) || (req.entry_index > lim);
        free_bit  = idx_reg - EW'(1);
    end

    // word check of the scan and the free
    always_comb
    begin
        base_w    = BW'(chk_addr_reg) << 5;
        lim_w     = BW'(lim);
        rem_w     = (lim_w > base_w) ? lim_w - base_w : '0;
        mask      = (rem_w >= BW'(WB)) ? '1 : (WB'(1) << rem_w[4:0]) - WB'(1);
        free_bits = ~rdata_reg & mask;
        found     = |free_bits;
        pos       = bfa_pkg::lowest_set(free_bits);
        last_word = (lim_w <= base_w + BW'(WB)) || (chk_addr_reg == LAST_WORD);
        free_hit  = rdata_reg[free_bit[4:0]];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfa_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_WORD)
                begin
                    state_next = bfa_pkg::ST_IDLE;
                end
            end
            bfa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.operation == bfa_pkg::OP_ALLOC)
                    begin
                        state_next = bfa_pkg::ST_SCAN;
                    end
                    else if (idx_bad)
                    begin
                        state_next = bfa_pkg::ST_RESP;
                    end
                    else
                    begin
                        state_next = bfa_pkg::ST_FREE_RD;
                    end
                end
            end
            bfa_pkg::ST_SCAN:
            begin
                if (chk_valid_reg && (found || last_word))
                begin
                    state_next = bfa_pkg::ST_RESP;
                end
            end
            bfa_pkg::ST_FREE_RD:
            begin
                state_next = bfa_pkg::ST_FREE_MOD;
            end
            bfa_pkg::ST_FREE_MOD:
            begin
                state_next = bfa_pkg::ST_RESP;
            end
            bfa_pkg::ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = bfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfa_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        req.ready = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = scan_addr_reg;
        wr_en     = 1'b0;
        wr_addr   = chk_addr_reg;
        wr_data   = rdata_reg;
        out_load  = 1'b0;
        case (state_reg)
            bfa_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
            end
            bfa_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            bfa_pkg::ST_SCAN:
            begin
                rd_en = 1'b1;
                if (chk_valid_reg && found)
                begin
                    wr_en   = 1'b1;
                    wr_data = rdata_reg | (WB'(1) << pos);
                end
            end
            bfa_pkg::ST_FREE_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = WA'(free_bit >> 5);
            end
            bfa_pkg::ST_FREE_MOD:
            begin
                wr_en   = free_hit;
                wr_addr = WA'(free_bit >> 5);
                wr_data = rdata_reg & ~(WB'(1) << free_bit[4:0]);
            end
            bfa_pkg::ST_RESP:
            begin
                out_load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // usage map
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= map_mem[rd_addr];
        end
    end

    // sequencer and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfa_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            scan_addr_reg <= '0;
            chk_addr_reg  <= '0;
            chk_valid_reg <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == bfa_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + WA'(1);
            end
            if (state_reg == bfa_pkg::ST_SCAN)
            begin
                chk_addr_reg  <= scan_addr_reg;
                chk_valid_reg <= !(chk_valid_reg && (found || last_word));
                if (scan_addr_reg != LAST_WORD)
                begin
                    scan_addr_reg <= scan_addr_reg + WA'(1);
                end
                if (chk_valid_reg && found)
                begin
                    used_reg <= used_reg + EW'(1);
                end
            end
            else
            begin
                scan_addr_reg <= '0;
                chk_valid_reg <= 1'b0;
            end
            if (state_reg == bfa_pkg::ST_FREE_MOD && free_hit && used_reg != '0)
            begin
                used_reg <= used_reg - EW'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg        <= req.entry_index;
            res_number_reg <= '0;
            res_status_reg <= (req.operation == bfa_pkg::OP_FREE && idx_bad)
                              ? bfa_pkg::STATUS_RANGE : bfa_pkg::STATUS_OK;
        end
        if (state_reg == bfa_pkg::ST_SCAN && chk_valid_reg)
        begin
            if (found)
            begin
                res_number_reg <= EW'(base_w) + EW'(pos) + EW'(1);
                res_status_reg <= bfa_pkg::STATUS_OK;
            end
            else if (last_word)
            begin
                res_number_reg <= '0;
                res_status_reg <= bfa_pkg::STATUS_FULL;
            end
        end
        if (out_load)
        begin
            out_number_reg <= res_number_reg;
            out_status_reg <= res_status_reg;
            out_free_reg   <= free_left;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.entry_number = out_number_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.free_count   = out_free_reg;

endmodule

// ===== tb/sv/tb_bitmap_first_free_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_bitmap_first_free_allocator
// self-checking bench for the first-free bitmap allocator: a local copy of the
// usage map and used count predicts entry number, status and free count of
// every request; directed corner cases come first, then random allocate and
// free traffic over several entry limits, with idle and stall phases on both
// channels and one long response hold-off
// ----------------------------------------------------------------------------
module tb_bitmap_first_free_allocator;

    localparam int    MAP_BITS     = bfa_pkg::MAP_BITS_DEF;
    localparam int    HOLD_CYCLES  = 400;
    localparam int    DRAIN_CYCLES = 300;
    localparam int    PHASES       = 6;
    localparam longint TIMEOUT     = 64'd60_000_000;

    typedef struct
    {
        bfa_pkg::op_t                op;
        logic [bfa_pkg::ENTRY_W-1:0] index;
    } request_t;

    typedef struct
    {
        logic [bfa_pkg::ENTRY_W-1:0] number;
        bfa_pkg::status_t            status;
        logic [bfa_pkg::ENTRY_W-1:0] free_cnt;
    } alloc_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [bfa_pkg::ADDR_W-1:0]   paddr;
    logic [bfa_pkg::DATA_W-1:0]   pwdata;
    logic [bfa_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    bfa_req_if req_ch();
    bfa_rsp_if rsp_ch();

    // predictor state
    bit                           in_use [MAP_BITS];
    int                           entries_used;
    logic [bfa_pkg::ENTRY_W-1:0]  limit_reg;

    request_t             pending_reqs[$];
    alloc_result_t        expected_rsps[$];
    bit                   req_taken;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    bit                   hold_on;
    int                   fail_count;

    int ph_limit [PHASES] = '{37, 8192, 100, 8, 16383, 64};
    int ph_send  [PHASES] = '{0, 82, 0, 19, 0, 19};
    int ph_recv  [PHASES] = '{0, 0, 82, 19, 0, 19};
    int ph_count [PHASES] = '{160, 120, 140, 120, 100, 80};

    bitmap_first_free_allocator dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #(TIMEOUT);
        $display("FAIL bitmap_first_free_allocator");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("mismatch: %s got %0d expected %0d", what, got, want);
    endtask

    function automatic alloc_result_t apply_request(input bfa_pkg::op_t op,
                                                    input logic [bfa_pkg::ENTRY_W-1:0] idx);
        alloc_result_t r;
        int            lim;
        bit            found;
        lim = int'(limit_reg);
        if (lim > MAP_BITS)
        begin
            lim = MAP_BITS;
        end
        r.number = '0;
        r.status = bfa_pkg::STATUS_OK;
        found    = 1'b0;
        if (op == bfa_pkg::OP_ALLOC)
        begin
            for (int b = 0; b < lim && !found; b++)
            begin
                if (!in_use[b])
                begin
                    in_use[b] = 1'b1;
                    entries_used++;
                    r.number = bfa_pkg::ENTRY_W'(b + 1);
                    found    = 1'b1;
                end
            end
            if (!found)
            begin
                r.status = bfa_pkg::STATUS_FULL;
            end
        end
        else if (idx == 0 || int'(idx) > lim)
        begin
            r.status = bfa_pkg::STATUS_RANGE;
        end
        else if (in_use[idx - 1])
        begin
            in_use[idx - 1] = 1'b0;
            if (entries_used > 0)
            begin
                entries_used--;
            end
        end
        r.free_cnt = (lim > entries_used) ? bfa_pkg::ENTRY_W'(lim - entries_used) : '0;
        return r;
    endfunction

    // request driver
    always @(posedge clk)
    begin : req_accept
        if (req_ch.valid && req_ch.ready)
        begin
            expected_rsps.push_back(apply_request(bfa_pkg::op_t'(req_ch.operation),
                                                  req_ch.entry_index));
            void'(pending_reqs.pop_front());
            req_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin : req_drive
        if (!req_ch.valid || req_taken)
        begin
            req_taken = 1'b0;
            if (rst_n && pending_reqs.size() != 0 &&
                $urandom_range(99) >= send_idle_pct)
            begin
                req_ch.valid       <= 1'b1;
                req_ch.operation   <= pending_reqs[0].op;
                req_ch.entry_index <= pending_reqs[0].index;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // response side
    always @(negedge clk)
    begin : rsp_ready_drive
        rsp_ch.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin : rsp_hold_off
        wait (hold_on);
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
    end

    always @(posedge clk)
    begin : rsp_check
        alloc_result_t want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                report_mismatch("response with none outstanding",
                                int'(rsp_ch.entry_number), 0);
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp_ch.entry_number !== want.number)
                begin
                    report_mismatch("entry_number", int'(rsp_ch.entry_number),
                                    int'(want.number));
                end
                if (rsp_ch.status !== want.status)
                begin
                    report_mismatch("status", int'(rsp_ch.status), int'(want.status));
                end
                if (rsp_ch.free_count !== want.free_cnt)
                begin
                    report_mismatch("free_count", int'(rsp_ch.free_count),
                                    int'(want.free_cnt));
                end
            end
        end
    end

    task automatic queue_req(input bfa_pkg::op_t op, input int idx);
        request_t r;
        r.op    = op;
        r.index = bfa_pkg::ENTRY_W'(idx);
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // apb write of the entry limit, then read it back
    task automatic write_limit(input int value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bfa_pkg::ADDR_W'(4 * int'(bfa_pkg::REG_ENTRY_LIMIT));
        pwdata  <= bfa_pkg::DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        limit_reg = bfa_pkg::ENTRY_W'(value);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (prdata !== bfa_pkg::DATA_W'(limit_reg))
        begin
            report_mismatch("entry_limit readback", int'(prdata), int'(limit_reg));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic queue_random(input int lim_cfg, input int count);
        int lim_eff;
        int focus;
        int pick;
        lim_eff = (lim_cfg > MAP_BITS) ? MAP_BITS : lim_cfg;
        focus   = (lim_eff < 300) ? lim_eff : 300;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                queue_req(bfa_pkg::OP_ALLOC, $urandom_range(16383));
            end
            else if (pick < 85 && focus > 0)
            begin
                queue_req(bfa_pkg::OP_FREE, $urandom_range(focus, 1));
            end
            else if (pick < 92 && lim_eff > 0)
            begin
                queue_req(bfa_pkg::OP_FREE, $urandom_range(lim_eff, 1));
            end
            else
            begin
                queue_req(bfa_pkg::OP_FREE, $urandom_range(16383));
            end
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_ch.valid       = 1'b0;
        req_ch.operation   = bfa_pkg::OP_ALLOC;
        req_ch.entry_index = '0;
        rsp_ch.ready       = 1'b0;
        req_taken          = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        hold_on            = 1'b0;
        fail_count         = 0;
        entries_used       = 0;
        limit_reg          = bfa_pkg::LIMIT_RESET;
        foreach (in_use[i])
        begin
            in_use[i] = 1'b0;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // clearing pass runs before the first request is taken
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);

        // reset limit: index zero, top entry, all-ones index, reuse, double free
        queue_req(bfa_pkg::OP_FREE, 0);
        queue_req(bfa_pkg::OP_FREE, 8192);
        queue_req(bfa_pkg::OP_FREE, 16383);
        queue_req(bfa_pkg::OP_ALLOC, 0);
        queue_req(bfa_pkg::OP_ALLOC, 16383);
        queue_req(bfa_pkg::OP_ALLOC, 8192);
        queue_req(bfa_pkg::OP_FREE, 2);
        queue_req(bfa_pkg::OP_ALLOC, 0);
        queue_req(bfa_pkg::OP_FREE, 2);
        queue_req(bfa_pkg::OP_FREE, 2);
        queue_req(bfa_pkg::OP_FREE, 8191);
        wait_drained();

        // limit lowered below entries in use
        write_limit(1);
        queue_req(bfa_pkg::OP_ALLOC, 0);
        queue_req(bfa_pkg::OP_FREE, 3);
        queue_req(bfa_pkg::OP_FREE, 1);
        queue_req(bfa_pkg::OP_ALLOC, 0);
        queue_req(bfa_pkg::OP_ALLOC, 0);
        wait_drained();

        // no entries managed
        write_limit(0);
        queue_req(bfa_pkg::OP_ALLOC, 0);
        queue_req(bfa_pkg::OP_FREE, 1);
        wait_drained();

        // limit above map size saturates
        write_limit(13000);
        queue_req(bfa_pkg::OP_FREE, 8193);
        queue_req(bfa_pkg::OP_FREE, 8192);
        queue_req(bfa_pkg::OP_ALLOC, 0);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            send_idle_pct  = ph_send[p];
            recv_stall_pct = ph_recv[p];
            write_limit(ph_limit[p]);
            if (p == 4)
            begin
                hold_on = 1'b1;
            end
            queue_random(ph_limit[p], ph_count[p]);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASS bitmap_first_free_allocator");
        end
        else
        begin
            $display("FAIL bitmap_first_free_allocator");
        end
        $finish;
    end

endmodule
